>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CHK_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cursor store check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cursor store check failed");

`endif

>>> hdl/cseq_pkg.sv
// ----------------------------------------------------------------------------
// cseq_pkg
// Shared constants and codes for the cursor sequence store.
// ----------------------------------------------------------------------------
package cseq_pkg;

  localparam int DEPTH_DEFAULT       = 16;
  localparam int VALUE_WIDTH_DEFAULT = 32;
  localparam int OP_WIDTH            = 3;
  localparam int STATUS_WIDTH        = 2;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_START   = 3'd0,
    OP_END     = 3'd1,
    OP_ADVANCE = 3'd2,
    OP_INSERT  = 3'd3,
    OP_ATTACH  = 3'd4,
    OP_REMOVE  = 3'd5
  } op_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK    = 2'd0,
    ST_NOCUR = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast shift command seen by every cell
  typedef enum logic [1:0] {
    SH_HOLD  = 2'd0,
    SH_OPEN  = 2'd1,
    SH_CLOSE = 2'd2
  } shift_t;

endpackage

>>> hdl/cseq_in_if.sv
// ----------------------------------------------------------------------------
// cseq_in_if
// Command channel: operation and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cseq_in_if #(
  parameter int VALUE_WIDTH = cseq_pkg::VALUE_WIDTH_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic [cseq_pkg::OP_WIDTH-1:0] operation;
  logic [VALUE_WIDTH-1:0]        item_value;

  modport source (output valid, output operation, output item_value, input ready);
  modport sink   (input valid, input operation, input item_value, output ready);
endinterface

>>> hdl/cseq_out_if.sv
// ----------------------------------------------------------------------------
// cseq_out_if
// Result channel: status, cursor view and count, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cseq_out_if #(
  parameter int VALUE_WIDTH = cseq_pkg::VALUE_WIDTH_DEFAULT,
  parameter int COUNT_WIDTH = 5
);
  logic                              valid;
  logic                              ready;
  logic [cseq_pkg::STATUS_WIDTH-1:0] status;
  logic                              has_current;
  logic [VALUE_WIDTH-1:0]            current_value;
  logic [COUNT_WIDTH-1:0]            item_count;

  modport source (output valid, output status, output has_current,
                  output current_value, output item_count, input ready);
  modport sink   (input valid, input status, input has_current,
                  input current_value, input item_count, output ready);
endinterface

>>> hdl/cseq_cell.sv
// ----------------------------------------------------------------------------
// cseq_cell
// One storage cell of the chain; takes its left or right neighbor or the new value on a shift.
// ----------------------------------------------------------------------------
module cseq_cell #(
  parameter int IDX         = 0,
  parameter int DEPTH       = cseq_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = cseq_pkg::VALUE_WIDTH_DEFAULT,
  localparam int PW         = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  cseq_pkg::shift_t       shift,
  input  logic [PW-1:0]          pos,
  input  logic [VALUE_WIDTH-1:0] ins_value,
  input  logic [VALUE_WIDTH-1:0] prev_value,
  input  logic [VALUE_WIDTH-1:0] next_value,
  output logic [VALUE_WIDTH-1:0] value
);

  localparam logic [PW-1:0] MY_POS = PW'(IDX);

  always_ff @(posedge clk) begin
    case (shift)
      cseq_pkg::SH_OPEN: begin
        // cells above the gap move up, the gap takes the new value
        if (MY_POS > pos) begin
          value <= prev_value;
        end else if (MY_POS == pos) begin
          value <= ins_value;
        end
      end
      cseq_pkg::SH_CLOSE: begin
        if (MY_POS >= pos) begin
          value <= next_value;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/cseq_ctrl.sv
// ----------------------------------------------------------------------------
// cseq_ctrl
// Cursor and count registers; decodes each command into a shift for the chain.
// ----------------------------------------------------------------------------
module cseq_ctrl #(
  parameter int DEPTH = cseq_pkg::DEPTH_DEFAULT,
  localparam int CW   = $clog2(DEPTH + 1),
  localparam int PW   = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [cseq_pkg::OP_WIDTH-1:0] operation,
  output cseq_pkg::shift_t              shift,
  output logic [PW-1:0]                 pos,
  output logic [CW-1:0]                 cursor,
  output logic [CW-1:0]                 count,
  output cseq_pkg::status_t             status
);

  logic [CW-1:0]     cursor_next;
  logic [CW-1:0]     count_next;
  cseq_pkg::status_t status_next;
  cseq_pkg::shift_t  shift_dec;
  logic [CW-1:0]     gap;
  logic              full;

  assign full = (count == CW'(DEPTH));

  always_comb begin
    shift_dec   = cseq_pkg::SH_HOLD;
    gap         = '0;
    cursor_next = cursor;
    count_next  = count;
    status_next = cseq_pkg::ST_OK;
    case (operation)
      cseq_pkg::OP_START: begin
        cursor_next = (count != '0) ? CW'(1) : '0;
      end
      cseq_pkg::OP_END: begin
        cursor_next = count;
      end
      cseq_pkg::OP_ADVANCE: begin
        if (cursor == '0) begin
          status_next = cseq_pkg::ST_NOCUR;
        end else if (cursor < count) begin
          cursor_next = cursor + CW'(1);
        end else begin
          cursor_next = '0;
        end
      end
      cseq_pkg::OP_INSERT: begin
        if (full) begin
          status_next = cseq_pkg::ST_FULL;
        end else begin
          gap         = (cursor != '0) ? cursor - CW'(1) : '0;
          shift_dec   = cseq_pkg::SH_OPEN;
          count_next  = count + CW'(1);
          cursor_next = gap + CW'(1);
        end
      end
      cseq_pkg::OP_ATTACH: begin
        if (full) begin
          status_next = cseq_pkg::ST_FULL;
        end else begin
          gap         = (cursor != '0) ? cursor : count;
          shift_dec   = cseq_pkg::SH_OPEN;
          count_next  = count + CW'(1);
          cursor_next = gap + CW'(1);
        end
      end
      cseq_pkg::OP_REMOVE: begin
        if (cursor == '0) begin
          status_next = cseq_pkg::ST_NOCUR;
        end else begin
          gap        = cursor - CW'(1);
          shift_dec  = cseq_pkg::SH_CLOSE;
          count_next = count - CW'(1);
          // removing the tail leaves no current item
          if (cursor == count) begin
            cursor_next = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign shift = fire ? shift_dec : cseq_pkg::SH_HOLD;
  assign pos   = gap[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      count  <= '0;
      status <= cseq_pkg::ST_OK;
    end else if (fire) begin
      cursor <= cursor_next;
      count  <= count_next;
      status <= status_next;
    end
  end

endmodule

>>> hdl/cursor_sequence_store.sv
// ----------------------------------------------------------------------------
// cursor_sequence_store
// Ordered store of up to DEPTH values with a cursor, built as a chain of cells.
// ----------------------------------------------------------------------------
//   channel  | dir | payload                                        | handshake
//   in_ch    | in  | operation, item_value                          | valid/ready
//   out_ch   | out | status, has_current, current_value, item_count | valid/ready
//
// Each transfer on in_ch updates the cell chain, cursor and count at that edge;
// the result is registered from them in the following cycle, via pending.
// The next command is taken in the same cycle the result transfers out.
// A stall on out_ch holds the result and blocks in_ch.
// Synchronous reset empties the store; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cursor_sequence_store #(
  parameter int DEPTH       = cseq_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = cseq_pkg::VALUE_WIDTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  cseq_in_if.sink    in_ch,
  cseq_out_if.source out_ch
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH);

  logic                   fire;
  logic                   pending;
  cseq_pkg::shift_t       shift;
  logic [PW-1:0]          pos;
  logic [CW-1:0]          cursor;
  logic [CW-1:0]          count;
  cseq_pkg::status_t      status;
  logic [CW-1:0]          cursor_m1;
  logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
  logic [VALUE_WIDTH-1:0] prev_value [DEPTH];
  logic [VALUE_WIDTH-1:0] next_value [DEPTH];

  assign in_ch.ready = !pending && (!out_ch.valid || out_ch.ready);
  assign fire        = in_ch.valid && in_ch.ready;

  cseq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .operation (in_ch.operation),
    .shift     (shift),
    .pos       (pos),
    .cursor    (cursor),
    .count     (count),
    .status    (status)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_value[i] = in_ch.item_value;
    end else begin : g_body
      assign prev_value[i] = cell_value[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_value[i] = cell_value[i];
    end else begin : g_inner
      assign next_value[i] = cell_value[i+1];
    end

    cseq_cell #(
      .IDX         (i),
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .shift      (shift),
      .pos        (pos),
      .ins_value  (in_ch.item_value),
      .prev_value (prev_value[i]),
      .next_value (next_value[i]),
      .value      (cell_value[i])
    );
  end

  assign cursor_m1 = cursor - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending      <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      pending <= fire;
      if (pending) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // load the result once the chain has settled after the transfer
  always_ff @(posedge clk) begin
    if (pending) begin
      out_ch.status        <= status;
      out_ch.has_current   <= (cursor != '0);
      out_ch.current_value <= (cursor != '0) ? cell_value[cursor_m1[PW-1:0]] : '0;
      out_ch.item_count    <= count;
    end
  end

endmodule

>>> hdl/cseq_checker.sv
// ----------------------------------------------------------------------------
// cseq_checker
// Port-level checks on the result channel of the cursor sequence store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cseq_checker #(
  parameter int DEPTH       = cseq_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = cseq_pkg::VALUE_WIDTH_DEFAULT,
  localparam int CW         = $clog2(DEPTH + 1)
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [cseq_pkg::STATUS_WIDTH-1:0] status,
  input logic                              has_current,
  input logic [VALUE_WIDTH-1:0]            current_value,
  input logic [CW-1:0]                     item_count
);

  `CHK_NEXT(a_hold_stalled, clk, rst, out_valid && !out_ready, out_valid && $stable(current_value) && $stable(item_count) && $stable(status) && $stable(has_current))
  `CHK_IMPLIES(a_count_range, clk, rst, out_valid, item_count <= CW'(DEPTH))
  `CHK_IMPLIES(a_empty_cursor, clk, rst, out_valid && !has_current, current_value == '0)
  `CHK_IMPLIES(a_full_count, clk, rst, out_valid && status == cseq_pkg::ST_FULL, item_count == CW'(DEPTH))
  `CHK_IMPLIES(a_nocur_flag, clk, rst, out_valid && status == cseq_pkg::ST_NOCUR, !has_current)

endmodule

bind cursor_sequence_store cseq_checker #(
  .DEPTH       (DEPTH),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .has_current   (out_ch.has_current),
  .current_value (out_ch.current_value),
  .item_count    (out_ch.item_count)
);
